@@ hw/rtl/lsr_pkg.sv @@
// shared types and constants for the lifo stack with reverse
package lsr_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 4;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_PEEK    = 2'd2,
    OP_REVERSE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    op_e                      opcode;
    logic signed [DATA_W-1:0] push_value;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_e                  status;
    logic [COUNT_W-1:0]       entry_count;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD_LO,
    S_RD_HI,
    S_WR_LO,
    S_WR_HI,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    RD_TOP,
    RD_LO,
    RD_HI
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_PUSH,
    WR_LO,
    WR_HI
  } wr_sel_e;

  typedef enum logic [2:0] {
    RES_OK_ZERO,
    RES_OK_DATA,
    RES_FULL,
    RES_EMPTY_NEG,
    RES_EMPTY_ZERO
  } res_kind_e;

  typedef struct packed {
    logic      load_in;
    rd_sel_e   rd_sel;
    logic      capture_tmp;
    logic      wr_en;
    wr_sel_e   wr_sel;
    logic      lvl_inc;
    logic      lvl_dec;
    logic      ptr_init;
    logic      ptr_step;
    logic      res_load;
    res_kind_e res_kind;
    logic      load_out;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic multi;
    logic more;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hw/rtl/lsr_dp.sv @@
// datapath: entry store, fill level, swap pointers, result and output registers
module lsr_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsr_pkg::in_req_t  in_req_i,
  input  lsr_pkg::dp_cmd_t  cmd_i,
  output lsr_pkg::dp_stat_t stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output lsr_pkg::out_rsp_t out_rsp_o
);
  import lsr_pkg::*;

  logic [DATA_W-1:0]  mem [STACK_DEPTH];
  logic [DATA_W-1:0]  rd_q;
  logic [DATA_W-1:0]  tmp_q;
  logic [DATA_W-1:0]  val_q;
  op_e                op_q;
  logic [LVL_W-1:0]   level_q;
  logic [PTR_W-1:0]   lo_q, hi_q;
  logic [DATA_W-1:0]  res_data_q;
  status_e            res_status_q;
  logic               out_valid_q;
  out_rsp_t           out_q;

  logic [LVL_W-1:0]   lvl_m1;
  logic [PTR_W-1:0]   top_addr;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   wr_addr;
  logic [DATA_W-1:0]  wr_data;
  logic [PTR_W+1:0]   lo_ext;
  logic [PTR_W+1:0]   hi_ext;
  logic [LVL_W+3:0]   lvl_ext;

  assign lvl_m1   = level_q - LVL_W'(1);
  assign top_addr = lvl_m1[PTR_W-1:0];
  assign lo_ext   = (PTR_W+2)'(lo_q) + (PTR_W+2)'(2);
  assign hi_ext   = (PTR_W+2)'(hi_q);
  assign lvl_ext  = (LVL_W+4)'(level_q);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_LO:   rd_addr = lo_q;
      RD_HI:   rd_addr = hi_q;
      default: rd_addr = top_addr;
    endcase
    case (cmd_i.wr_sel)
      WR_LO: begin
        wr_addr = lo_q;
        wr_data = rd_q;
      end
      WR_HI: begin
        wr_addr = hi_q;
        wr_data = tmp_q;
      end
      default: begin
        wr_addr = level_q[PTR_W-1:0];
        wr_data = val_q;
      end
    endcase
  end

  // store with one write port and one read port: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_req_i.opcode;
      val_q <= in_req_i.push_value;
    end
    if (cmd_i.capture_tmp) begin
      tmp_q <= rd_q;
    end
    if (cmd_i.ptr_init) begin
      lo_q <= '0;
      hi_q <= top_addr;
    end else if (cmd_i.ptr_step) begin
      lo_q <= lo_q + PTR_W'(1);
      hi_q <= hi_q - PTR_W'(1);
    end
    if (cmd_i.res_load) begin
      case (cmd_i.res_kind)
        RES_OK_DATA: begin
          res_data_q   <= rd_q;
          res_status_q <= ST_OK;
        end
        RES_FULL: begin
          res_data_q   <= '0;
          res_status_q <= ST_FULL;
        end
        RES_EMPTY_NEG: begin
          res_data_q   <= '1;
          res_status_q <= ST_EMPTY;
        end
        RES_EMPTY_ZERO: begin
          res_data_q   <= '0;
          res_status_q <= ST_EMPTY;
        end
        default: begin
          res_data_q   <= '0;
          res_status_q <= ST_OK;
        end
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.read_value  <= res_data_q;
      out_q.status      <= res_status_q;
      out_q.entry_count <= lvl_ext[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.lvl_inc) begin
        level_q <= level_q + LVL_W'(1);
      end else if (cmd_i.lvl_dec) begin
        level_q <= lvl_m1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (level_q == LVL_W'(STACK_DEPTH));
  assign stat_o.empty    = (level_q == '0);
  assign stat_o.multi    = (level_q > LVL_W'(1));
  assign stat_o.more     = (lo_ext < hi_ext);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ hw/rtl/lsr_ctrl.sv @@
// controller: sequences one request and the pairwise swap walk of a reverse
module lsr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsr_pkg::dp_stat_t stat_i,
  output lsr_pkg::dp_cmd_t  cmd_o
);
  import lsr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    cmd_o.rd_sel   = RD_TOP;
    cmd_o.wr_sel   = WR_PUSH;
    cmd_o.res_kind = RES_OK_ZERO;

    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = 1'b1;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.res_load = 1'b1;
        state_d        = S_RESP;
        case (stat_i.op)
          OP_PUSH: begin
            if (stat_i.full) begin
              cmd_o.res_kind = RES_FULL;
            end else begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.lvl_inc  = 1'b1;
              cmd_o.res_kind = RES_OK_ZERO;
            end
          end
          OP_POP: begin
            if (stat_i.empty) begin
              cmd_o.res_kind = RES_EMPTY_NEG;
            end else begin
              cmd_o.lvl_dec  = 1'b1;
              cmd_o.res_kind = RES_OK_DATA;
            end
          end
          OP_PEEK: begin
            cmd_o.res_kind = stat_i.empty ? RES_EMPTY_ZERO : RES_OK_DATA;
          end
          default: begin
            if (stat_i.empty) begin
              cmd_o.res_kind = RES_EMPTY_ZERO;
            end else begin
              cmd_o.res_kind = RES_OK_ZERO;
              if (stat_i.multi) begin
                cmd_o.ptr_init = 1'b1;
                state_d        = S_RD_LO;
              end
            end
          end
        endcase
      end
      S_RD_LO: begin
        cmd_o.rd_sel = RD_LO;
        state_d      = S_RD_HI;
      end
      S_RD_HI: begin
        cmd_o.capture_tmp = 1'b1;
        cmd_o.rd_sel      = RD_HI;
        state_d           = S_WR_LO;
      end
      S_WR_LO: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_LO;
        state_d      = S_WR_HI;
      end
      S_WR_HI: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_HI;
        cmd_o.ptr_step = 1'b1;
        state_d        = stat_i.more ? S_RD_LO : S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/lifo_stack_with_reverse.sv @@
// top level of the bounded lifo stack with in-place reverse
// A bounded stack of STACK_DEPTH signed 32-bit words. Each request carries an
// opcode (push, pop, peek, reverse) and a push value, and yields exactly one
// response with a data word, a status (ok, full, empty) and the entry count
// after the operation. Push, pop and peek accept the request, execute it
// against the store and then load the output register. A reverse of n
// entries does floor(n/2) pairwise swaps, each needing two reads and two
// writes through the store's single read and single write port. The
// output register lets the next request be accepted while a response is
// still stalled downstream. Stack entries hold no reset value; only written
// entries are ever returned.
module lifo_stack_with_reverse (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lsr_pkg::in_req_t  in_req_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lsr_pkg::out_rsp_t out_rsp_o
);
  import lsr_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // state machine: one request at a time, swap walk for reverse
  lsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, fill level, swap pointers and output register
  lsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
